// File: hdl/upd_gcrc_pkg.sv
`default_nettype none

package upd_gcrc_pkg;

  localparam int RetryLimitDefault = 3;

  localparam logic [4:0] TypeGoodcrc   = 5'h01;
  localparam logic [2:0] MaxObjects    = 3'd7;
  localparam logic [5:0] GoodcrcBytes  = 6'd6;
  localparam logic [1:0] RevReset      = 2'd1;
  localparam logic [1:0] RevUnsupported = 2'd3;

  typedef enum logic [1:0] {
    ReqTransmit = 2'd0,
    ReqRxFrame  = 2'd1,
    ReqTimeout  = 2'd2,
    ReqIdReset  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    KindMsg     = 2'd0,
    KindGoodcrc = 2'd1,
    KindTxOk    = 2'd2,
    KindTxFail  = 2'd3
  } kind_t;

endpackage

`default_nettype wire

// File: hdl/usb_pd_goodcrc_protocol_layer.sv
// USB PD protocol layer, fixed Source / DFP: header build, GoodCRC wait and
// retry, automatic GoodCRC replies.
// Input stream (s_axis): one word per event; tuser carries the event code
// (transmit request, received frame, GoodCRC timeout, message ID reset),
// tdata the request and received-frame fields.
// Output stream (m_axis): at most one word per event; tuser carries the
// result kind (send header, send GoodCRC, success, fail), tdata the header
// and message ID.
// cfg port: writes spec_revision; always ready, a value of 3 is dropped.
// An event is registered in the input register on accept, and its result is
// then registered in the output register that drives m_axis. One event per
// cycle is sustained while m_axis is not stalled.
// A stalled m_axis holds its word; the input register keeps one more event,
// after which s_axis_tready drops until the output word is taken.
// Reset (rst, synchronous): message ID 0, idle, spec_revision 1, both
// stream registers empty.
`default_nettype none

module usb_pd_goodcrc_protocol_layer #(
  parameter int RETRY_LIMIT = upd_gcrc_pkg::RetryLimitDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tx_type[4:0], object_count[8:5], rx_is_sop0[9], rx_byte_count[15:10],
  // rx_header[31:16]
  input  wire logic [31:0] s_axis_tdata,
  // req_type[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // out_header[15:0], out_msg_id[18:16], zero[23:19]
  output logic [23:0]      m_axis_tdata,
  // out_kind[1:0]
  output logic [1:0]       m_axis_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_data
);
  import upd_gcrc_pkg::*;

  localparam logic [1:0] RetryMax = RETRY_LIMIT[1:0];

  // configuration
  logic [1:0] spec_revision;

  // input register
  logic        in_vld;
  req_t        in_req;
  logic [4:0]  in_tx_type;
  logic [3:0]  in_objs;
  logic        in_sop0;
  logic [5:0]  in_bytes;
  logic [15:0] in_hdr;

  // protocol state
  logic [2:0]  message_id, message_id_next;
  logic        awaiting, awaiting_next;
  logic [1:0]  attempt_count, attempt_count_next;
  logic [15:0] pending_header, pending_header_next;

  // result register
  logic        out_vld;
  kind_t       out_kind;
  logic [15:0] out_header;
  logic [2:0]  out_msg_id;

  logic        res_vld;
  kind_t       res_kind;
  logic [15:0] res_header;
  logic [2:0]  res_id;
  logic        advance;
  logic        is_goodcrc;
  logic [15:0] tx_header;
  logic [15:0] reply_header;

  assign advance       = in_vld && (!out_vld || m_axis_tready);
  assign s_axis_tready = !in_vld || advance;
  assign cfg_ready     = 1'b1;

  assign m_axis_tvalid = out_vld;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tdata  = {5'd0, out_msg_id, out_header};

  assign is_goodcrc = (in_bytes == GoodcrcBytes) && (in_hdr[4:0] == TypeGoodcrc);

  assign tx_header    = {1'b0, in_objs[2:0], message_id, 1'b1, spec_revision, 1'b1,
                         in_tx_type};
  assign reply_header = {4'd0, in_hdr[11:9], 1'b1, in_hdr[7:6], 1'b1, TypeGoodcrc};

  always_comb begin
    res_vld             = 1'b0;
    res_kind            = KindMsg;
    res_header          = 16'd0;
    res_id              = message_id;
    message_id_next     = message_id;
    awaiting_next       = awaiting;
    attempt_count_next  = attempt_count;
    pending_header_next = pending_header;
    case (in_req)
      ReqTransmit: begin
        res_vld = 1'b1;
        if (awaiting || (in_objs > {1'b0, MaxObjects})) begin
          res_kind = KindTxFail;
        end else begin
          res_kind            = KindMsg;
          res_header          = tx_header;
          pending_header_next = tx_header;
          awaiting_next       = 1'b1;
          attempt_count_next  = 2'd1;
        end
      end
      ReqRxFrame: begin
        if (awaiting) begin
          if (is_goodcrc && (in_hdr[11:9] == message_id)) begin
            res_vld            = 1'b1;
            res_kind           = KindTxOk;
            message_id_next    = message_id + 3'd1;
            awaiting_next      = 1'b0;
            attempt_count_next = 2'd0;
          end
        end else if (in_sop0 && (in_bytes >= GoodcrcBytes) && !is_goodcrc) begin
          res_vld    = 1'b1;
          res_kind   = KindGoodcrc;
          res_header = reply_header;
          res_id     = in_hdr[11:9];
        end
      end
      ReqTimeout: begin
        if (awaiting) begin
          res_vld = 1'b1;
          if (attempt_count < RetryMax) begin
            res_kind           = KindMsg;
            res_header         = pending_header;
            attempt_count_next = attempt_count + 2'd1;
          end else begin
            res_kind           = KindTxFail;
            awaiting_next      = 1'b0;
            attempt_count_next = 2'd0;
          end
        end
      end
      ReqIdReset: begin
        message_id_next    = 3'd0;
        awaiting_next      = 1'b0;
        attempt_count_next = 2'd0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      spec_revision <= RevReset;
    end else if (cfg_valid && cfg_ready && (cfg_data != RevUnsupported)) begin
      spec_revision <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_req     <= req_t'(s_axis_tuser);
      in_tx_type <= s_axis_tdata[4:0];
      in_objs    <= s_axis_tdata[8:5];
      in_sop0    <= s_axis_tdata[9];
      in_bytes   <= s_axis_tdata[15:10];
      in_hdr     <= s_axis_tdata[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      message_id     <= 3'd0;
      awaiting       <= 1'b0;
      attempt_count  <= 2'd0;
      pending_header <= 16'd0;
    end else if (advance) begin
      message_id     <= message_id_next;
      awaiting       <= awaiting_next;
      attempt_count  <= attempt_count_next;
      pending_header <= pending_header_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= res_vld;
    end else if (m_axis_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_vld) begin
      out_kind   <= res_kind;
      out_header <= res_header;
      out_msg_id <= res_id;
    end
  end

  // a transmission in flight always has at least one attempt counted
  assert property (@(posedge clk) disable iff (rst)
    awaiting |-> (attempt_count != 2'd0) && (attempt_count <= RetryMax))
    else $error("attempt count out of range while awaiting GoodCRC");

  assert property (@(posedge clk) disable iff (rst)
    !awaiting |-> (attempt_count == 2'd0))
    else $error("attempt count nonzero while idle");

  // a success result advances the message ID by one
  assert property (@(posedge clk) disable iff (rst)
    (advance && res_vld && (res_kind == KindTxOk)) |=>
      (message_id == $past(message_id) + 3'd1) && !awaiting)
    else $error("message ID did not advance on GoodCRC match");

  assert property (@(posedge clk) disable iff (rst)
    spec_revision != RevUnsupported)
    else $error("unsupported spec revision stored");

endmodule

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import upd_gcrc_pkg::*;

  localparam int RetryLimit = RetryLimitDefault;
  localparam int CycleLimit = 1_000_000;
  localparam int RandomItems = 1900;
  localparam int Phases = 6;
  localparam logic [1:0] PhaseRev [Phases] = '{2'd3, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1};

  typedef struct packed {
    kind_t       kind;
    logic [15:0] header;
    logic [2:0]  id;
  } pd_word_t;

  class pd_layer_model;
    logic [1:0]  revision;
    logic [2:0]  msg_id;
    bit          awaiting;
    int unsigned attempts;
    logic [15:0] pending_hdr;
    pd_word_t    expected[$];
    int          errors;
    int          effective;

    function new();
      revision = RevReset;
      msg_id = '0;
      awaiting = 1'b0;
      attempts = 0;
      pending_hdr = '0;
      errors = 0;
      effective = 0;
    endfunction

    function void set_revision(logic [1:0] v);
      if (v != RevUnsupported) revision = v;
    endfunction

    function void push(kind_t k, logic [15:0] h, logic [2:0] id);
      pd_word_t w;
      w.kind = k;
      w.header = h;
      w.id = id;
      expected.push_back(w);
    endfunction

    function void note_event(req_t req, logic [31:0] d);
      logic [4:0]  mt;
      logic [3:0]  oc;
      logic        sop;
      logic [5:0]  bc;
      logic [15:0] hdr;
      bit          is_gcrc;
      effective++;
      mt = d[4:0];
      oc = d[8:5];
      sop = d[9];
      bc = d[15:10];
      hdr = d[31:16];
      is_gcrc = (bc == GoodcrcBytes) && (hdr[4:0] == TypeGoodcrc);
      case (req)
        ReqTransmit: begin
          if (awaiting || oc > 4'(MaxObjects)) begin
            push(KindTxFail, '0, msg_id);
          end else begin
            pending_hdr = {1'b0, oc[2:0], msg_id, 1'b1, revision, 1'b1, mt};
            awaiting = 1'b1;
            attempts = 1;
            push(KindMsg, pending_hdr, msg_id);
          end
        end
        ReqRxFrame: begin
          if (awaiting) begin
            if (is_gcrc && hdr[11:9] == msg_id) begin
              push(KindTxOk, '0, msg_id);
              msg_id = msg_id + 3'd1;
              awaiting = 1'b0;
              attempts = 0;
            end
          end else if (sop && bc >= GoodcrcBytes && !is_gcrc) begin
            push(KindGoodcrc, {4'h0, hdr[11:9], 1'b1, hdr[7:6], 1'b1, TypeGoodcrc}, hdr[11:9]);
          end
        end
        ReqTimeout: begin
          if (awaiting) begin
            if (attempts < RetryLimit) begin
              attempts++;
              push(KindMsg, pending_hdr, msg_id);
            end else begin
              awaiting = 1'b0;
              attempts = 0;
              push(KindTxFail, '0, msg_id);
            end
          end
        end
        default: begin
          msg_id = '0;
          awaiting = 1'b0;
          attempts = 0;
        end
      endcase
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_word(logic [1:0] kind, logic [23:0] data);
      pd_word_t w;
      if (expected.size() == 0) begin
        report($sformatf("unexpected word kind %0d data %h", kind, data));
        return;
      end
      w = expected.pop_front();
      if (kind != w.kind) report($sformatf("kind %0d, want %0d", kind, w.kind));
      if (data[15:0] != w.header) report($sformatf("header %h, want %h", data[15:0], w.header));
      if (data[18:16] != w.id) report($sformatf("msg id %0d, want %0d", data[18:16], w.id));
      if (data[23:19] != '0) report($sformatf("pad bits %b not zero", data[23:19]));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_data = '0;

  pd_layer_model pd;
  bit quiet = 1'b0;
  bit hold_request = 1'b0;
  int cycles = 0;

  usb_pd_goodcrc_protocol_layer #(
    .RETRY_LIMIT(RetryLimit)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] frame_word(logic sop, logic [5:0] bc, logic [15:0] hdr);
    return {hdr, bc, sop, 4'($urandom), 5'($urandom)};
  endfunction

  function automatic logic [31:0] tx_word(logic [4:0] mt, logic [3:0] oc);
    return {16'($urandom), 6'($urandom_range(0, 34)), 1'($urandom), oc, mt};
  endfunction

  function automatic logic [31:0] goodcrc_word(logic [2:0] id);
    logic [15:0] h;
    h = 16'($urandom);
    h[4:0] = TypeGoodcrc;
    h[11:9] = id;
    return frame_word(1'($urandom), GoodcrcBytes, h);
  endfunction

  // valid stays high between back-to-back words
  task automatic send_word(input req_t req, input logic [31:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= req;
    s_axis_tdata <= data;
    do @(posedge clk); while (!s_axis_tready);
    pd.note_event(req, data);
  endtask

  task automatic write_revision(input logic [1:0] v);
    s_axis_tvalid <= 1'b0;
    while (pd.expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pd.set_revision(v);
  endtask

  task automatic random_exchange();
    int r;
    int k;
    logic [15:0] h;
    logic [5:0] bc;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      send_word(ReqTransmit, tx_word(5'($urandom),
                ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15))
                                            : 4'($urandom_range(0, 7))));
      k = $urandom_range(0, 4);
      repeat (k) begin
        if ($urandom_range(0, 5) == 0)
          send_word(ReqRxFrame, frame_word(1'($urandom), 6'($urandom_range(0, 34)),
                                           16'($urandom)));
        else if ($urandom_range(0, 7) == 0)
          send_word(ReqTransmit, tx_word(5'($urandom), 4'($urandom)));
        send_word(ReqTimeout, 32'($urandom));
      end
      r = $urandom_range(0, 99);
      if (r < 75) send_word(ReqRxFrame, goodcrc_word(pd.msg_id));
      else if (r < 85)
        send_word(ReqRxFrame, goodcrc_word(pd.msg_id + 3'($urandom_range(1, 7))));
      else if (r < 92) send_word(ReqIdReset, 32'($urandom));
    end else if (r < 80) begin
      h = 16'($urandom);
      if ($urandom_range(0, 9) < 7) begin
        bc = 6'($urandom_range(6, 34));
        if (bc == GoodcrcBytes && h[4:0] == TypeGoodcrc) h[0] = 1'b0;
        send_word(ReqRxFrame, frame_word(1'b1, bc, h));
      end else begin
        send_word(ReqRxFrame, frame_word(1'($urandom), 6'($urandom_range(0, 34)), h));
      end
    end else if (r < 85) begin
      send_word(ReqTimeout, 32'($urandom));
    end else if (r < 90) begin
      send_word(ReqIdReset, 32'($urandom));
    end else begin
      send_word(req_t'($urandom_range(0, 3)), tx_word(5'($urandom), 4'($urandom)));
    end
  endtask

  // sink side: random backpressure plus one long hold-off on request
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) pd.check_word(m_axis_tuser, m_axis_tdata);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        stall_left = pick_gap();
        m_axis_tready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  initial begin
    int target;
    pd = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_revision(2'd2);

    send_word(ReqTransmit, tx_word(5'd0, 4'd0));
    repeat (3) send_word(ReqTimeout, 32'h0);
    send_word(ReqTransmit, tx_word(5'h1F, 4'd7));
    send_word(ReqTransmit, tx_word(5'd3, 4'd1));
    send_word(ReqRxFrame, goodcrc_word(pd.msg_id + 3'd1));
    send_word(ReqRxFrame, frame_word(1'b1, 6'd20, 16'h1234));
    send_word(ReqRxFrame, frame_word(1'b0, GoodcrcBytes, {4'h0, pd.msg_id, 9'h001}));
    send_word(ReqTransmit, tx_word(5'd2, 4'd15));
    send_word(ReqTimeout, 32'hFFFF_FFFF);
    send_word(ReqRxFrame, frame_word(1'b1, GoodcrcBytes, 16'hFFFF));
    send_word(ReqRxFrame, frame_word(1'b1, 6'd34, 16'h0000));
    send_word(ReqRxFrame, frame_word(1'b1, 6'd5, 16'h0C42));
    send_word(ReqRxFrame, frame_word(1'b0, 6'd12, 16'h0C42));
    send_word(ReqRxFrame, frame_word(1'b1, GoodcrcBytes, 16'h0E41));
    send_word(ReqRxFrame, frame_word(1'b1, 6'd7, 16'h0E41));
    send_word(ReqTransmit, tx_word(5'd4, 4'd3));
    send_word(ReqIdReset, 32'hFFFF_FFFF);
    send_word(ReqTimeout, 32'h0);
    send_word(ReqTransmit, tx_word(5'd6, 4'd2));
    send_word(ReqRxFrame, goodcrc_word(pd.msg_id));

    for (int p = 0; p < Phases; p++) begin
      write_revision(PhaseRev[p]);
      quiet = (p == 3);
      if (p == 1) hold_request = 1'b1;
      target = pd.effective + RandomItems / Phases;
      while (pd.effective < target) random_exchange();
    end

    s_axis_tvalid <= 1'b0;
    while (pd.expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pd.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/upd_gcrc_pkg.sv
hdl/usb_pd_goodcrc_protocol_layer.sv
bench/tb.sv
